>>> hdl/ncc_pkg.sv
// ============================================================================
// ncc_pkg
// Shared sizes, opcodes and command/result types of the nearest cell classifier.
// ============================================================================
`default_nettype none

package ncc_pkg;

    localparam int MAX_CELLS    = 64;
    localparam int FEATURE_BITS = 16;
    localparam int LABEL_BITS   = 4;
    localparam int OPC_W        = 2;

    localparam int IDX_W  = $clog2(MAX_CELLS);
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int SQ_W   = 2 * FEATURE_BITS;
    localparam int DIST_W = SQ_W + 1;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CQ_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CQ_CNT_W  = $clog2(CMD_DEPTH + 1);

    typedef enum logic [OPC_W-1:0] {
        OPC_CLASSIFY = 2'd0,
        OPC_TRAIN    = 2'd1,
        OPC_LOAD     = 2'd2,
        OPC_NONE     = 2'd3
    } t_opcode;

    // decoded command handed from front to back
    typedef struct packed {
        logic                    search;
        logic                    append_on_miss;
        logic                    append_always;
        logic [FEATURE_BITS-1:0] x;
        logic [FEATURE_BITS-1:0] y;
        logic [LABEL_BITS-1:0]   tag;
    } t_cmd;

    typedef struct packed {
        logic [LABEL_BITS-1:0] best_label;
        logic [DIST_W-1:0]     best_dist_sq;
        logic                  label_match;
        logic                  inserted;
        logic                  table_full;
        logic                  status;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/ncc_if.sv
// ============================================================================
// ncc_if
// Valid/ready channels of the classifier: input items and result beats.
// ============================================================================
`default_nettype none

interface ncc_in_if import ncc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OPC_W-1:0]        opcode;
    logic [FEATURE_BITS-1:0] feature_x;
    logic [FEATURE_BITS-1:0] feature_y;
    logic [LABEL_BITS-1:0]   class_tag;

    modport source (output valid, output opcode, output feature_x, output feature_y,
                    output class_tag, input ready);
    modport sink   (input valid, input opcode, input feature_x, input feature_y,
                    input class_tag, output ready);
endinterface

interface ncc_out_if import ncc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] best_label;
    logic [DIST_W-1:0]     best_dist_sq;
    logic                  label_match;
    logic                  inserted;
    logic                  table_full;
    logic                  status;

    modport source (output valid, output best_label, output best_dist_sq,
                    output label_match, output inserted, output table_full,
                    output status, input ready);
    modport sink   (input valid, input best_label, input best_dist_sq,
                    input label_match, input inserted, input table_full,
                    input status, output ready);
endinterface

`default_nettype wire

>>> hdl/nearest_cell_classifier.sv
// ============================================================================
// nearest_cell_classifier
// Nearest-neighbor classifier over a table of labelled 2-D cells (Q0.16).
// ============================================================================
//
//  channel   dir  beat contents
//  --------  ---  ---------------------------------------------------------
//  i_item    in   opcode, feature_x, feature_y, class_tag
//  o_result  out  best_label, best_dist_sq, label_match, inserted,
//                 table_full, status
//
//  Classify/train: the back end pops the command, makes one table read per
//    stored cell, drains the two pipeline stages and writes the result; the
//    single read port of the cell table makes the scan read one cell at a time.
//    Load, unused opcode or a search on an empty table: pop, then result write.
//  Front and queue keep taking beats while the back end scans, up to the
//    queue depth plus the front register.
//  Reset is synchronous, active low; the cell count clears, table contents
//    are left as they are (never read above the count).
//  A stalled result holds in the output register; the next command waits.
//
`default_nettype none

module nearest_cell_classifier import ncc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ncc_in_if.sink    i_item,
    ncc_out_if.source o_result
);

    // front -> queue
    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;

    // queue -> back
    logic w_pop_valid;
    logic w_pop_ready;
    t_cmd w_pop_cmd;

    // decode and register each accepted beat
    ncc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    // lets the front stall independently of the scan
    ncc_cmd_fifo u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // table scan, insert and result register
    ncc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .i_cmd       (w_pop_cmd),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

>>> hdl/ncc_front.sv
// ============================================================================
// ncc_front
// Accepts input beats, decodes the opcode and registers a command.
// ============================================================================
`default_nettype none

module ncc_front import ncc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ncc_in_if.sink    i_item,
    output logic      o_push_valid,
    input  logic      i_push_ready,
    output t_cmd      o_push_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign i_item.ready = !r_valid || i_push_ready;

    always_comb begin
        n_cmd                = '0;
        n_cmd.x              = i_item.feature_x;
        n_cmd.y              = i_item.feature_y;
        n_cmd.tag            = i_item.class_tag;
        unique case (t_opcode'(i_item.opcode))
            OPC_CLASSIFY: begin
                n_cmd.search = 1'b1;
            end
            OPC_TRAIN: begin
                n_cmd.search         = 1'b1;
                n_cmd.append_on_miss = 1'b1;
            end
            OPC_LOAD: begin
                n_cmd.append_always = 1'b1;
            end
            OPC_NONE: begin
                // unused code: all-zero result, state untouched
                n_cmd.search = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
            if (i_item.valid) begin
                r_cmd <= n_cmd;
            end
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

`default_nettype wire

>>> hdl/ncc_cmd_fifo.sv
// ============================================================================
// ncc_cmd_fifo
// Short command queue decoupling the front from the search engine.
// ============================================================================
`default_nettype none

module ncc_cmd_fifo import ncc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd                r_slot [CMD_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_push_ready = (r_cnt != CQ_CNT_W'(CMD_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
        ptr_inc = (p == CQ_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + CQ_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CQ_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ncc_back.sv
// ============================================================================
// ncc_back
// Cell table, nearest-cell scan pipeline, insert logic and result register.
// ============================================================================
`default_nettype none

module ncc_back import ncc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    ncc_out_if.source o_result
);

    typedef struct packed {
        logic [FEATURE_BITS-1:0] x;
        logic [FEATURE_BITS-1:0] y;
        logic [LABEL_BITS-1:0]   label;
    } t_cell;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_out_valid;
    t_result          r_out;

    t_cell r_cells [MAX_CELLS];
    t_cell r_rd_data;

    // scan pipeline
    logic                  r_v1, r_first1;
    logic                  r_v2, r_first2;
    logic [SQ_W-1:0]       r_sq_x, r_sq_y;
    logic [LABEL_BITS-1:0] r_lbl2;
    logic [DIST_W-1:0]     r_best_d;
    logic [LABEL_BITS-1:0] r_best_lbl;

    logic                    w_rd_en;
    logic                    w_last_rd;
    logic [FEATURE_BITS-1:0] w_dx, w_dy;
    logic [DIST_W-1:0]       w_sum;
    logic                    w_out_free;
    logic                    w_searched;
    logic                    w_match;
    logic                    w_ins_req;
    logic                    w_full;
    logic                    w_wr_en;
    t_result                 n_res;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign w_rd_en     = (r_state == ST_SCAN);
    assign w_last_rd   = (CNT_W'(r_rd_idx) + CNT_W'(1) == r_count);

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_cells[r_count[IDX_W-1:0]] <= '{x: r_cmd.x, y: r_cmd.y, label: r_cmd.tag};
        end
        if (w_rd_en) begin
            r_rd_data <= r_cells[r_rd_idx];
        end
    end

    assign w_dx  = (r_rd_data.x >= r_cmd.x) ? r_rd_data.x - r_cmd.x : r_cmd.x - r_rd_data.x;
    assign w_dy  = (r_rd_data.y >= r_cmd.y) ? r_rd_data.y - r_cmd.y : r_cmd.y - r_rd_data.y;
    assign w_sum = DIST_W'(r_sq_x) + DIST_W'(r_sq_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1     <= w_rd_en;
            r_first1 <= w_rd_en && (r_rd_idx == '0);
            r_v2     <= r_v1;
            r_first2 <= r_first1;
            r_sq_x   <= SQ_W'(w_dx) * SQ_W'(w_dx);
            r_sq_y   <= SQ_W'(w_dy) * SQ_W'(w_dy);
            r_lbl2   <= r_rd_data.label;
            // strict less-than keeps the lowest index on a tie
            if (r_v2 && (r_first2 || (w_sum < r_best_d))) begin
                r_best_d   <= w_sum;
                r_best_lbl <= r_lbl2;
            end
        end
    end

    // result of the current command
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_searched = r_cmd.search && (r_count != '0);
    assign w_match    = w_searched && (r_best_lbl == r_cmd.tag);
    assign w_ins_req  = r_cmd.append_always || (r_cmd.append_on_miss && !w_match);
    assign w_full     = (r_count == CNT_W'(MAX_CELLS));
    assign w_wr_en    = (r_state == ST_FINISH) && w_out_free && w_ins_req && !w_full;

    always_comb begin
        n_res              = '0;
        n_res.best_label   = w_searched ? r_best_lbl : '0;
        n_res.best_dist_sq = w_searched ? r_best_d : '0;
        n_res.label_match  = w_match;
        n_res.inserted     = w_ins_req && !w_full;
        n_res.table_full   = w_ins_req && w_full;
        n_res.status       = r_cmd.search && (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new beat loads as the old one leaves
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_rd_idx <= '0;
                        r_state  <= (i_cmd.search && (r_count != '0)) ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                    if (w_last_rd) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out <= n_res;
                        if (w_wr_en) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.best_label   = r_out.best_label;
    assign o_result.best_dist_sq = r_out.best_dist_sq;
    assign o_result.label_match  = r_out.label_match;
    assign o_result.inserted     = r_out.inserted;
    assign o_result.table_full   = r_out.table_full;
    assign o_result.status       = r_out.status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CELLS))
        else $error("cell count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + CNT_W'(1)))
        else $error("cell count moved by more than one");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("scan reads past stored cells");

    a_ins_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.inserted && r_out.table_full))
        else $error("result both inserted and dropped");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> (r_out.best_dist_sq == '0) && !r_out.label_match)
        else $error("empty-table result carries search data");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Randomized check of the nearest cell classifier: items are sent on the input
// channel, a behavioral copy of the cell table predicts every result beat, and
// the result channel is compared beat by beat while both sides idle and stall.
// ============================================================================

module testbench import ncc_pkg::*; ();

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 6;
    // nothing accepted on either channel for this long means the block hung;
    // well above the long hold-off plus a full 64-cell scan
    localparam int STALL_LIMIT       = 4000;
    localparam int HOLD_OFF_CYCLES   = 400;
    // wait past a full table scan at the end
    localparam int TAIL_CYCLES       = MAX_CELLS + 40;
    localparam int GROW_ITEMS        = 400;
    localparam int FULL_TABLE_ITEMS  = 600;
    localparam int PROFILE_ITEMS     = 100;

    typedef logic [FEATURE_BITS-1:0] t_feat;
    typedef logic [LABEL_BITS-1:0]   t_label;
    typedef logic [DIST_W-1:0]       t_dist;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ncc_in_if  item_ch ();
    ncc_out_if result_ch ();

    nearest_cell_classifier dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the cell table. Updated at each accepted input beat,
    // so it always reflects the items in the order the block takes them.
    // ------------------------------------------------------------------------
    t_feat   known_x     [MAX_CELLS];
    t_feat   known_y     [MAX_CELLS];
    t_label  known_label [MAX_CELLS];
    int      known_count = 0;

    // expected result beats, oldest first
    t_result expected_beats [$];
    int unsigned fail_count = 0;

    // idling knobs, changed by the test tasks
    int unsigned tx_gap_max   = 2;
    int unsigned rx_stall_pct = 20;
    int unsigned burst_left   = 0;
    bit          hold_off_req = 1'b0;

    initial forever #CLK_HALF i_clk = ~i_clk;

    // squared Euclidean distance, exact in Q0.32 plus one carry bit
    function automatic t_dist sq_dist(t_feat ax, t_feat ay, t_feat bx, t_feat by);
        t_dist dx, dy;
        dx = (ax >= bx) ? t_dist'(ax - bx) : t_dist'(bx - ax);
        dy = (ay >= by) ? t_dist'(ay - by) : t_dist'(by - ay);
        return dx * dx + dy * dy;
    endfunction

    // linear scan; strict less-than keeps the lowest index on a tie
    function automatic void find_nearest(input t_feat px, input t_feat py, output bit found,
                                         output t_label lbl, output t_dist best_d);
        t_dist d;
        found  = (known_count != 0);
        lbl    = '0;
        best_d = '0;
        for (int i = 0; i < known_count; i++) begin
            d = sq_dist(known_x[i], known_y[i], px, py);
            if (i == 0 || d < best_d) begin
                best_d = d;
                lbl    = known_label[i];
            end
        end
    endfunction

    // returns 0 when the table is full and the point is dropped
    function automatic bit store_cell(t_feat px, t_feat py, t_label tag);
        if (known_count >= MAX_CELLS)
            return 1'b0;
        known_x[known_count]     = px;
        known_y[known_count]     = py;
        known_label[known_count] = tag;
        known_count++;
        return 1'b1;
    endfunction

    function automatic t_result predict_result(t_opcode op, t_feat px, t_feat py, t_label tag);
        t_result res;
        bit      found;
        t_label  lbl;
        t_dist   best_d;
        res = '0;
        if (op == OPC_CLASSIFY || op == OPC_TRAIN) begin
            find_nearest(px, py, found, lbl, best_d);
            if (!found) begin
                res.status = 1'b1;
            end else begin
                res.best_label   = lbl;
                res.best_dist_sq = best_d;
                res.label_match  = (lbl == tag);
            end
            // empty table counts as a miss, so train appends
            if (op == OPC_TRAIN && !res.label_match) begin
                if (store_cell(px, py, tag))
                    res.inserted = 1'b1;
                else
                    res.table_full = 1'b1;
            end
        end else if (op == OPC_LOAD) begin
            if (store_cell(px, py, tag))
                res.inserted = 1'b1;
            else
                res.table_full = 1'b1;
        end
        // unused opcode: all fields zero, table untouched
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input monitor: predict on every accepted beat (pre-edge values).
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : predict_beat
        t_result pred;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            pred = predict_result(t_opcode'(item_ch.opcode),
                                  item_ch.feature_x, item_ch.feature_y,
                                  item_ch.class_tag);
            expected_beats.insert(expected_beats.size(), pred);
        end
    end

    task automatic compare_field(string name, t_dist want, t_dist got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: each accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_beat
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with no expected result pending");
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                compare_field("best_label",   t_dist'(want.best_label),
                              t_dist'(result_ch.best_label));
                compare_field("best_dist_sq", want.best_dist_sq, result_ch.best_dist_sq);
                compare_field("label_match",  t_dist'(want.label_match),
                              t_dist'(result_ch.label_match));
                compare_field("inserted",     t_dist'(want.inserted),
                              t_dist'(result_ch.inserted));
                compare_field("table_full",   t_dist'(want.table_full),
                              t_dist'(result_ch.table_full));
                compare_field("status",       t_dist'(want.status),
                              t_dist'(result_ch.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no beat on either channel.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: short random stall runs, plus one long hold-off on
    // request, counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        int unsigned stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (stall_left != 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(99) < rx_stall_pct) begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(3);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them. valid stays
    // high across a burst; it is lowered only when a gap starts.
    // ------------------------------------------------------------------------
    task automatic send_item(t_opcode op, t_feat px, t_feat py, t_label tag);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max);
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.feature_x <= px;
        item_ch.feature_y <= py;
        item_ch.class_tag <= tag;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // mostly random, with corners and a coarse grid so ties and exact hits occur
    function automatic t_feat pick_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return t_feat'(1) << (FEATURE_BITS - 1);
            3: return t_feat'($urandom_range(3)) << (FEATURE_BITS - 2);
            default: return t_feat'($urandom);
        endcase
    endfunction

    // one random item; half the searches carry the label they will find
    task automatic send_random_item(output bit ignored);
        int unsigned pick;
        t_opcode     op;
        t_feat       px, py;
        t_label      tag, near_lbl;
        t_dist       near_dist;
        bit          found;
        pick = $urandom_range(99);
        if (pick < 55)
            op = OPC_CLASSIFY;
        else if (pick < 85)
            op = OPC_TRAIN;
        else if (pick < 95)
            op = OPC_LOAD;
        else
            op = OPC_NONE;
        px = pick_coord();
        py = pick_coord();
        find_nearest(px, py, found, near_lbl, near_dist);
        tag = (found && $urandom_range(1)) ? near_lbl : t_label'($urandom);
        send_item(op, px, py, tag);
        ignored = (op == OPC_NONE);
    endtask

    // random items under rotating idle profiles; optionally stop once full
    task automatic run_random(int unsigned n_items, bit stop_when_full);
        int unsigned counted;
        bit          ignored;
        counted = 0;
        while (counted < n_items && !(stop_when_full && known_count >= MAX_CELLS)) begin
            if (counted % PROFILE_ITEMS == 0) begin
                case ((counted / PROFILE_ITEMS) % 4)
                    0: begin tx_gap_max = 3; rx_stall_pct = 30; end
                    1: begin tx_gap_max = 0; rx_stall_pct = 0;  end   // full streaming
                    2: begin tx_gap_max = 8; rx_stall_pct = 10; end
                    default: begin tx_gap_max = 0; rx_stall_pct = 75; end
                endcase
            end
            send_random_item(ignored);
            if (!ignored)
                counted++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // searches on an empty table report status; train on empty still appends
    task automatic test_empty_table();
        send_item(OPC_CLASSIFY, '0, '0, '1);
        send_item(OPC_NONE,     '0, '0, '0);
        send_item(OPC_TRAIN,    '1, '1, t_label'(5));
    endtask

    task automatic test_directed_cases();
        // largest possible distance: opposite corners
        send_item(OPC_CLASSIFY, '0, '0, t_label'(5));
        // two cells on the same point: the lower index must win the tie
        send_item(OPC_LOAD,     '0, '0, t_label'(10));
        send_item(OPC_LOAD,     '0, '0, t_label'(3));
        send_item(OPC_CLASSIFY, '0, '0, t_label'(3));
        // exact hit with matching label: no insert
        send_item(OPC_TRAIN,    '0, '0, t_label'(10));
        // near miss with other label: insert
        send_item(OPC_TRAIN,    t_feat'(1), '0, t_label'(3));
        send_item(OPC_CLASSIFY, t_feat'(1) << (FEATURE_BITS - 1),
                  t_feat'(1) << (FEATURE_BITS - 1), '0);
        // unused opcode with every field bit set is ignored
        send_item(OPC_NONE,     '1, '1, '1);
        send_item(OPC_LOAD,     '1, '0, '1);
        send_item(OPC_LOAD,     '0, '1, '0);
        send_item(OPC_CLASSIFY, '1, '0, '1);
        send_item(OPC_TRAIN,    ~(t_feat'(1) << (FEATURE_BITS - 1)),
                  t_feat'(1) << (FEATURE_BITS - 1), t_label'(7));
    endtask

    // receiver holds off long while items keep coming: queue fills, input stalls
    task automatic test_back_pressure();
        tx_gap_max   = 0;
        hold_off_req = 1'b1;
        repeat (16)
            send_item(OPC_CLASSIFY, pick_coord(), pick_coord(), t_label'($urandom));
        tx_gap_max   = 2;
    endtask

    task automatic test_random_growth();
        run_random(GROW_ITEMS, 1'b1);
    endtask

    // fill to capacity, then drop inserts from load and from a missed train
    task automatic test_full_table();
        t_feat  px, py;
        t_label lbl;
        t_dist  best_d;
        bit     found;
        tx_gap_max   = 2;
        rx_stall_pct = 20;
        while (known_count < MAX_CELLS)
            send_item(OPC_LOAD, pick_coord(), pick_coord(), t_label'($urandom));
        send_item(OPC_LOAD, '1, '1, '1);
        px = pick_coord();
        py = pick_coord();
        find_nearest(px, py, found, lbl, best_d);
        send_item(OPC_TRAIN, px, py, lbl + t_label'(1));
        send_item(OPC_TRAIN, px, py, lbl);
        send_item(OPC_CLASSIFY, px, py, lbl);
    endtask

    task automatic test_random_full();
        run_random(FULL_TABLE_ITEMS, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = '0;
        item_ch.feature_x = '0;
        item_ch.feature_y = '0;
        item_ch.class_tag = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_cases();
        test_back_pressure();
        test_random_growth();
        test_full_table();
        test_random_full();

        item_ch.valid <= 1'b0;
        rx_stall_pct   = 20;
        while (expected_beats.size() != 0) @(posedge i_clk);
        // catch stray extra result beats
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/ncc_pkg.sv
hdl/ncc_if.sv
hdl/ncc_front.sv
hdl/ncc_cmd_fifo.sv
hdl/ncc_back.sv
hdl/nearest_cell_classifier.sv
sim/testbench.sv
